@@ design/isrt_pkg.sv @@
`timescale 1ns / 1ps

package isrt_pkg;

   // Store depth and the width at which values are compared and kept.
   localparam int MAX_ITEMS   = 16;
   localparam int VALUE_WIDTH = 32;

   // Width of the value fields on the channels.
   localparam int FIELD_WIDTH = 32;

   // Fill counter must be able to hold MAX_ITEMS itself.
   localparam int COUNT_WIDTH = $clog2(MAX_ITEMS + 1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [FIELD_WIDTH-1:0] field_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;  // place the key at its sorted position
      logic drain;   // shift every cell one place toward the output
   } cell_ctrl_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   // Channel value to stored value: low VALUE_WIDTH bits, sign extended if wider.
   function automatic value_type to_value(field_type v);
      return value_type'(v);
   endfunction

   // Stored value to channel value: truncated or sign extended to the field.
   function automatic field_type to_field(value_type v);
      return field_type'(v);
   endfunction

endpackage

@@ design/isrt_if.sv @@
`timescale 1ns / 1ps

// Input channel: one value to sort per word.
interface isrt_req_if;
   import isrt_pkg::*;

   logic      valid;
   logic      ready;
   field_type value;
   logic      is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink (input valid, input value, input is_last, output ready);
endinterface

// Result channel: sorted values, one per word.
interface isrt_rsp_if;
   import isrt_pkg::*;

   logic      valid;
   logic      ready;
   field_type sorted_value;
   logic      end_of_set;
   logic      overflow;

   modport source (output valid, output sorted_value, output end_of_set, output overflow,
                   input ready);
   modport sink (input valid, input sorted_value, input end_of_set, input overflow,
                 output ready);
endinterface

@@ design/isrt_cell.sv @@
`timescale 1ns / 1ps

module isrt_cell import isrt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  value_type     key,
   input  value_type     prev_value,
   input  logic          prev_valid,
   input  logic          prev_open,
   input  value_type     next_value,
   input  logic          next_valid,
   output value_type     value,
   output logic          valid,
   output logic          open
);

   value_type value_ff, value_in;
   logic      valid_ff, valid_in;

   // The key belongs here or further left when this cell is empty or holds a
   // strictly greater value; equal values keep arrival order.
   assign open = !valid_ff || (value_ff > key);

   // Insertion: cells past the insert point take their left neighbor, the
   // insert point takes the key. Drain: every cell takes its right neighbor.
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.drain) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (ctrl.insert) begin
         if (prev_open) begin
            value_in = prev_value;
            valid_in = prev_valid;
         end else if (open) begin
            value_in = key;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

@@ design/insertion_sorter.sv @@
`timescale 1ns / 1ps

// Insertion sorter. Signed values arrive one per word on req and are placed
// at once into an ascending chain of MAX_ITEMS cells; every cell compares the
// new value with its own and shifts right in the same cycle, so a word that
// does not close the set is taken every cycle. The word marked is_last is
// inserted too, then the chain shifts its contents toward rsp one value per
// cycle unless rsp stalls, smallest first, end_of_set on the final word.
// A closing word therefore holds req off until all n stored values, n being
// the stored count, have been drained. Equal values leave in arrival order.
// Words arriving while the chain is full are dropped and every result of
// that set carries overflow. The chain is empty again after the last result.
module insertion_sorter import isrt_pkg::*; (
   input logic      clock,
   input logic      reset,
   isrt_req_if.sink req,
   isrt_rsp_if.source rsp
);

   state_type     state_ff, state_in;
   count_type     count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic          rsp_valid_ff, rsp_valid_in;
   field_type     rsp_value_ff, rsp_value_in;
   logic          rsp_end_ff, rsp_end_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          req_take;
   logic          full;
   logic          drain_go;
   cell_ctrl_type ctrl;
   value_type     key;

   value_type     cell_value [MAX_ITEMS];
   logic          cell_valid [MAX_ITEMS];
   logic          cell_open  [MAX_ITEMS];

   assign key      = to_value(req.value);
   assign full     = (count_ff == count_type'(MAX_ITEMS));
   assign req_take = req.valid && req.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_take && req.is_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_go && (count_ff == count_type'(1))) begin
               state_in = ST_FILL;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   // State outputs.
   always_comb begin
      req.ready   = 1'b0;
      drain_go    = 1'b0;
      ctrl.insert = 1'b0;
      ctrl.drain  = 1'b0;
      case (state_ff)
         ST_FILL: begin
            req.ready   = 1'b1;
            ctrl.insert = req.valid && !full;
         end
         ST_DRAIN: begin
            drain_go   = !rsp_valid_ff || rsp.ready;
            ctrl.drain = drain_go;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   // Fill count and the dropped mark for the current set.
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (req_take) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + count_type'(1);
         end
      end else if (drain_go) begin
         count_in = count_ff - count_type'(1);
         if (count_ff == count_type'(1)) begin
            dropped_in = 1'b0;
         end
      end
   end

   // Output register: loaded from the head cell while draining.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (drain_go) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = to_field(cell_value[0]);
         rsp_end_in   = (count_ff == count_type'(1));
         rsp_ovf_in   = dropped_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sorted_value = rsp_value_ff;
   assign rsp.end_of_set   = rsp_end_ff;
   assign rsp.overflow     = rsp_ovf_ff;

   // The sorting chain; cell 0 holds the smallest value.
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      value_type prev_value;
      logic      prev_valid;
      logic      prev_open;
      value_type next_value;
      logic      next_valid;

      if (i == 0) begin : g_head
         assign prev_value = key;
         assign prev_valid = 1'b0;
         assign prev_open  = 1'b0;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_open  = cell_open[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign next_value = cell_value[i];
         assign next_valid = 1'b0;
      end else begin : g_inner
         assign next_value = cell_value[i+1];
         assign next_valid = cell_valid[i+1];
      end

      isrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key        (key),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .prev_open  (prev_open),
         .next_value (next_value),
         .next_valid (next_valid),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .open       (cell_open[i])
      );
   end

   // The fill count never exceeds the chain length.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(MAX_ITEMS))
      else $error("fill count beyond chain length");

   // The head cell is occupied exactly when the count is nonzero.
   assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (count_ff != '0))
      else $error("head cell occupancy disagrees with fill count");

   // A word can only have been dropped while the chain is full; the mark then
   // stays with the set until its last result has been loaded.
   assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> (full || (state_ff == ST_DRAIN)))
      else $error("dropped mark set while chain not full");

   // Loading the final result of a set leaves the chain empty.
   assert property (@(posedge clock) disable iff (reset)
      (drain_go && (count_ff == count_type'(1))) |=>
         (!cell_valid[0] && (state_ff == ST_FILL) && rsp.end_of_set))
      else $error("chain not empty after the final result");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import isrt_pkg::*;

   // One expected word on the result channel.
   typedef struct packed {
      field_type sorted_value;
      logic      end_of_set;
      logic      overflow;
   } sorted_word_type;

   // Ready patterns of the result receiver.
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_THREE_OF_FOUR,
      RX_RANDOM,
      RX_ALTERNATE
   } rx_mode_type;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int TAIL_CYCLES = 40;
   localparam int WORD_TARGET = 450;

   logic clock = 1'b0;
   logic reset = 1'b1;

   isrt_req_if req ();
   isrt_rsp_if rsp ();

   insertion_sorter DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #2 clock = ~clock;

   // Mirror of the sorting chain and the words it still owes.
   value_type       sorted_cells [MAX_ITEMS];
   int              cell_count = 0;
   bit              dropped = 1'b0;
   sorted_word_type expected_words [$];
   int              errors = 0;

   // Sender and receiver control.
   int  words_sent = 0;
   int  burst_left = 1;
   bit  gaps_on = 1'b1;
   bit  hold_start = 1'b0;
   int  idle_cycles = 0;

   // Insert one accepted word into the mirror; a closing word flushes it.
   task automatic predict_word(input field_type word_value, input logic word_last);
      value_type       key;
      int              pos;
      sorted_word_type next_word;
      key = value_type'(word_value);
      if (cell_count >= MAX_ITEMS) begin
         dropped = 1'b1;
      end else begin
         pos = cell_count;
         // Strictly greater keeps equal values in arrival order.
         while (pos > 0 && sorted_cells[pos-1] > key) begin
            sorted_cells[pos] = sorted_cells[pos-1];
            pos--;
         end
         sorted_cells[pos] = key;
         cell_count++;
      end
      if (word_last) begin
         for (int k = 0; k < cell_count; k++) begin
            next_word.sorted_value = field_type'(sorted_cells[k]);
            next_word.end_of_set   = (k == cell_count - 1);
            next_word.overflow     = dropped;
            expected_words.push_back(next_word);
         end
         cell_count = 0;
         dropped    = 1'b0;
      end
   endtask

   // Predict on accepted input words first, then check accepted results.
   always @(posedge clock) begin : check_words
      sorted_word_type oldest;
      if (!reset) begin
         if (req.valid && req.ready)
            predict_word(req.value, req.is_last);
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               errors++;
               $display("%0t: unexpected word: expected none, actual value %0d eos %0b ovf %0b",
                        $time, rsp.sorted_value, rsp.end_of_set, rsp.overflow);
            end else begin
               oldest = expected_words.pop_front();
               if (rsp.sorted_value !== oldest.sorted_value) begin
                  errors++;
                  $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                           $time, oldest.sorted_value, rsp.sorted_value);
               end
               if (rsp.end_of_set !== oldest.end_of_set) begin
                  errors++;
                  $display("%0t: end_of_set mismatch: expected %0b, actual %0b",
                           $time, oldest.end_of_set, rsp.end_of_set);
               end
               if (rsp.overflow !== oldest.overflow) begin
                  errors++;
                  $display("%0t: overflow mismatch: expected %0b, actual %0b",
                           $time, oldest.overflow, rsp.overflow);
               end
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: a ready pattern picked at random from four modes, plus long holds on request.
   initial begin : receiver
      rx_mode_type mode;
      int          phase;
      int          hold_left;
      mode      = RX_ALWAYS;
      phase     = 0;
      hold_left = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready = 1'b0;
         end else begin
            phase++;
            if (phase % 64 == 0)
               mode = rx_mode_type'($urandom_range(0, 3));
            case (mode)
               RX_ALWAYS:        rsp.ready = 1'b1;
               RX_THREE_OF_FOUR: rsp.ready = (phase % 4 != 0);
               RX_RANDOM:        rsp.ready = $urandom_range(0, 1);
               default:          rsp.ready = phase[0];
            endcase
         end
      end
   end

   // Offer one word from a falling edge until it is taken, then apply the burst gaps.
   task automatic send_word(input field_type word_value, input logic word_last);
      req.valid   = 1'b1;
      req.value   = word_value;
      req.is_last = word_last;
      do @(posedge clock); while (!req.ready);
      words_sent++;
      @(negedge clock);
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gaps_on) begin
            req.valid   = 1'b0;
            req.value   = field_type'($urandom);
            req.is_last = $urandom_range(0, 1);
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   endtask

   // Mix of full-range, clustered and extreme values so that duplicates occur.
   function automatic field_type random_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return field_type'($urandom);
         4, 5:       return field_type'($signed($urandom_range(0, 8)) - 4);
         6:          return $urandom_range(0, 1) ? field_type'(32'h7FFF_FFFF)
                                                 : field_type'(32'h8000_0000);
         7:          return field_type'($urandom_range(0, 255)) <<< 24;
         default:    return field_type'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   task automatic send_random_set(input int set_size);
      for (int k = 1; k <= set_size; k++)
         send_word(random_value(), k == set_size);
   endtask

   task automatic wait_until_drained();
      req.valid = 1'b0;
      while (expected_words.size() != 0)
         @(negedge clock);
   endtask

   // Both extremes, zero, plus and minus one, with repeated values.
   task automatic test_extremes();
      send_word(field_type'(0), 1'b0);
      send_word(field_type'(32'h7FFF_FFFF), 1'b0);
      send_word(field_type'(32'h8000_0000), 1'b0);
      send_word(field_type'(-1), 1'b0);
      send_word(field_type'(1), 1'b0);
      send_word(field_type'(32'h8000_0000), 1'b0);
      send_word(field_type'(32'h7FFF_FFFF), 1'b0);
      send_word(field_type'(-1), 1'b1);
   endtask

   // Sets made of the closing word alone, and a tiny set of equal values.
   task automatic test_single_word_sets();
      send_word(field_type'(32'h7FFF_FFFF), 1'b1);
      send_word(field_type'(32'h8000_0000), 1'b1);
      send_word(field_type'(0), 1'b1);
      send_word(field_type'(5), 1'b0);
      send_word(field_type'(5), 1'b1);
   endtask

   // Exactly full, full with the closing word dropped, and well past capacity.
   task automatic test_overflow();
      send_random_set(MAX_ITEMS);
      for (int k = 0; k < MAX_ITEMS; k++)
         send_word(random_value(), 1'b0);
      send_word(random_value(), 1'b1);
      send_random_set(MAX_ITEMS + 6);
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_backpressure();
      gaps_on    = 1'b0;
      hold_start = 1'b1;
      send_random_set(MAX_ITEMS);
      send_random_set(10);
      send_random_set(3);
      gaps_on = 1'b1;
   endtask

   // Sender stops until every result of the set has come back.
   task automatic test_pause_until_drained();
      send_random_set(12);
      wait_until_drained();
      send_random_set(7);
      wait_until_drained();
   endtask

   // Random sets, mostly within capacity, with gap-free stretches now and then.
   task automatic test_random_sets();
      int set_size;
      while (words_sent < WORD_TARGET) begin
         gaps_on  = ($urandom_range(0, 3) != 0);
         set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6)
                                                : $urandom_range(1, MAX_ITEMS);
         send_random_set(set_size);
      end
   endtask

   initial begin
      req.valid   = 1'b0;
      req.value   = '0;
      req.is_last = 1'b0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_single_word_sets();
      test_overflow();
      test_backpressure();
      test_pause_until_drained();
      test_random_sets();

      // Let the last set drain, then allow time for anything stray.
      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
